### sv/ted_pkg.sv
package ted_pkg;

  // Range allowed for the next UTF-8 continuation byte
  typedef enum logic [2:0] {
    RULE_ANY  = 3'd0,  // 0x80..0xBF
    RULE_A0BF = 3'd1,  // after 0xE0
    RULE_809F = 3'd2,  // after 0xED
    RULE_90BF = 3'd3,  // after 0xF0
    RULE_808F = 3'd4   // after 0xF4
  } utf8_rule_e;

  typedef enum logic [1:0] {
    ENC_UTF8    = 2'd0,
    ENC_GBK     = 2'd1,
    ENC_ASCII   = 2'd2,
    ENC_UNKNOWN = 2'd3
  } enc_e;

  // One checker step: a word is consumed from the input register
  typedef struct packed {
    logic valid;
    logic last;
  } step_t;

  localparam logic [7:0] ByteAsciiMax = 8'h7F;
  localparam logic [7:0] ContMin      = 8'h80;
  localparam logic [7:0] ContMax      = 8'hBF;
  localparam logic [7:0] Utf8Lead2Min = 8'hC2;
  localparam logic [7:0] Utf8Lead2Max = 8'hDF;
  localparam logic [7:0] Utf8E0       = 8'hE0;
  localparam logic [7:0] Utf8ED       = 8'hED;
  localparam logic [7:0] Utf8Lead3Max = 8'hEF;
  localparam logic [7:0] Utf8F0       = 8'hF0;
  localparam logic [7:0] Utf8F4       = 8'hF4;
  localparam logic [7:0] Cont9F       = 8'h9F;
  localparam logic [7:0] ContA0       = 8'hA0;
  localparam logic [7:0] Cont90       = 8'h90;
  localparam logic [7:0] Cont8F       = 8'h8F;
  localparam logic [7:0] GbkLeadMin   = 8'h81;
  localparam logic [7:0] GbkLeadMax   = 8'hFE;
  localparam logic [7:0] GbkTrailLo   = 8'h40;
  localparam logic [7:0] GbkTrailLoMx = 8'h7E;

endpackage

### sv/ted_utf8.sv
module ted_utf8
  import ted_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  step_t      step_i,
  input  logic [7:0] byte_i,
  output logic       valid_o   // text so far is complete strict UTF-8
);

  logic [1:0] pending_q, pending_d, pending_n;
  utf8_rule_e rule_q, rule_d, rule_n;
  logic       good_q, good_d, good_n;
  logic       cont_ok;

  always_comb begin
    case (rule_q)
      RULE_A0BF: cont_ok = (byte_i >= ContA0) && (byte_i <= ContMax);
      RULE_809F: cont_ok = (byte_i >= ContMin) && (byte_i <= Cont9F);
      RULE_90BF: cont_ok = (byte_i >= Cont90) && (byte_i <= ContMax);
      RULE_808F: cont_ok = (byte_i >= ContMin) && (byte_i <= Cont8F);
      default:   cont_ok = (byte_i >= ContMin) && (byte_i <= ContMax);
    endcase
  end

  always_comb begin
    pending_n = pending_q;
    rule_n    = rule_q;
    good_n    = good_q;
    if (good_q) begin
      if (pending_q != 2'd0) begin
        rule_n = RULE_ANY;
        if (cont_ok) begin
          pending_n = pending_q - 2'd1;
        end else begin
          good_n    = 1'b0;
          pending_n = 2'd0;
        end
      end else if (byte_i <= ByteAsciiMax) begin
        good_n = 1'b1;
      end else if (byte_i >= Utf8Lead2Min && byte_i <= Utf8Lead2Max) begin
        pending_n = 2'd1;
        rule_n    = RULE_ANY;
      end else if (byte_i == Utf8E0) begin
        pending_n = 2'd2;
        rule_n    = RULE_A0BF;
      end else if (byte_i == Utf8ED) begin
        pending_n = 2'd2;
        rule_n    = RULE_809F;
      end else if (byte_i > Utf8E0 && byte_i <= Utf8Lead3Max) begin
        pending_n = 2'd2;
        rule_n    = RULE_ANY;
      end else if (byte_i == Utf8F0) begin
        pending_n = 2'd3;
        rule_n    = RULE_90BF;
      end else if (byte_i == Utf8F4) begin
        pending_n = 2'd3;
        rule_n    = RULE_808F;
      end else if (byte_i > Utf8F0 && byte_i < Utf8F4) begin
        pending_n = 2'd3;
        rule_n    = RULE_ANY;
      end else begin
        good_n = 1'b0;
      end
    end
  end

  // A sequence left open at the end of the text fails
  assign valid_o = good_n && (pending_n == 2'd0);

  always_comb begin
    pending_d = pending_q;
    rule_d    = rule_q;
    good_d    = good_q;
    if (step_i.valid) begin
      if (step_i.last) begin
        pending_d = 2'd0;
        rule_d    = RULE_ANY;
        good_d    = 1'b1;
      end else begin
        pending_d = pending_n;
        rule_d    = rule_n;
        good_d    = good_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
      rule_q    <= RULE_ANY;
      good_q    <= 1'b1;
    end else begin
      pending_q <= pending_d;
      rule_q    <= rule_d;
      good_q    <= good_d;
    end
  end

`ifndef SYNTHESIS
  a_fail_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !good_q |-> pending_q == 2'd0)
    else $error("utf8 failure left continuation bytes pending");

  a_rule_only_after_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rule_q != RULE_ANY |-> pending_q == 2'd2 || pending_q == 2'd3)
    else $error("narrow continuation rule without a fresh multi-byte lead");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.valid && step_i.last |=> pending_q == 2'd0 && good_q && rule_q == RULE_ANY)
    else $error("utf8 state not returned to reset after last word");
`endif

endmodule

### sv/ted_gbk.sv
module ted_gbk
  import ted_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  step_t      step_i,
  input  logic [7:0] byte_i,
  output logic       valid_o   // text so far is complete well-formed GBK
);

  logic need_q, need_d, need_n;
  logic good_q, good_d, good_n;
  logic trail_ok;

  assign trail_ok = (byte_i >= GbkTrailLo && byte_i <= GbkTrailLoMx) ||
                    (byte_i >= ContMin && byte_i <= GbkLeadMax);

  always_comb begin
    need_n = need_q;
    good_n = good_q;
    if (good_q) begin
      if (need_q) begin
        need_n = 1'b0;
        good_n = trail_ok;
      end else if (byte_i >= GbkLeadMin && byte_i <= GbkLeadMax) begin
        need_n = 1'b1;
      end else if (byte_i > ByteAsciiMax) begin
        good_n = 1'b0;
      end
    end
  end

  // Drop the verdict if the text stops right after a lead byte
  assign valid_o = good_n && !need_n;

  always_comb begin
    need_d = need_q;
    good_d = good_q;
    if (step_i.valid) begin
      need_d = step_i.last ? 1'b0 : need_n;
      good_d = step_i.last ? 1'b1 : good_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= 1'b0;
      good_q <= 1'b1;
    end else begin
      need_q <= need_d;
      good_q <= good_d;
    end
  end

endmodule

### sv/text_encoding_detector.sv
// Text encoding detector: feed a text one byte per word on the slave stream,
// with tlast on its final byte. Strict UTF-8, GBK and ASCII are checked side
// by side; on the final byte one result word gives the three verdicts and the
// chosen encoding (UTF-8, else GBK, else ASCII, else unknown), and the checkers
// start afresh for the next text. Bytes that are not last produce no result.
// One byte is taken per cycle unless the input stalls: a byte sits in the input
// register while the checkers update, and the verdict for a last byte lands in the
// output register, from which the result word is offered. Only an output word left
// untaken while another text ends stalls the input.
module text_encoding_detector
  import ted_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [1:0] encoding, [2] utf8_valid,
                                       // [3] gbk_valid, [4] ascii_valid, [7:5] 0
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       consume, load_out, in_take;
  step_t      step;

  logic       utf8_ok, gbk_ok, ascii_ok;
  logic       ascii_q, ascii_d;
  enc_e       enc;

  logic       out_valid_q, out_valid_d;
  enc_e       out_enc_q;
  logic       out_utf8_q, out_gbk_q, out_ascii_q;

  // A last byte may only leave the input register when the output can take it
  assign consume  = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign load_out = consume && in_last_q;
  assign s_axis_tready_o = !in_valid_q || consume;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  assign step.valid = consume;
  assign step.last  = in_last_q;

  ted_utf8 u_utf8 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .valid_o (utf8_ok)
  );

  ted_gbk u_gbk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .valid_o (gbk_ok)
  );

  assign ascii_ok = ascii_q && !in_byte_q[7];

  always_comb begin
    if (utf8_ok) begin
      enc = ENC_UTF8;
    end else if (gbk_ok) begin
      enc = ENC_GBK;
    end else if (ascii_ok) begin
      enc = ENC_ASCII;
    end else begin
      enc = ENC_UNKNOWN;
    end
  end

  always_comb begin
    ascii_d = ascii_q;
    if (consume) begin
      ascii_d = in_last_q ? 1'b1 : ascii_ok;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ascii_q     <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      ascii_q     <= ascii_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (load_out) begin
      out_enc_q   <= enc;
      out_utf8_q  <= utf8_ok;
      out_gbk_q   <= gbk_ok;
      out_ascii_q <= ascii_ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_ascii_q, out_gbk_q, out_utf8_q, out_enc_q};

`ifndef SYNTHESIS
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(consume && in_last_q))
    else $error("result word raised without a consumed last byte");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && in_last_q && out_valid_q)
    else $error("input stalled without a pending result");

  a_enc_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_enc_q == ENC_UTF8) == out_utf8_q &&
                    (out_enc_q != ENC_ASCII || out_ascii_q))
    else $error("encoding verdict disagrees with validity flags");
`endif

endmodule

### tb/text_encoding_detector_checker.sv
module text_encoding_detector_checker
  import ted_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // last_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [1:0] encoding, [2] utf8_valid,
                                        // [3] gbk_valid, [4] ascii_valid, [7:5] 0
  output int unsigned fails_o,
  output int unsigned verdicts_due_o
);

  typedef struct {
    enc_e       enc;
    logic       utf8_ok;
    logic       gbk_ok;
    logic       ascii_ok;
  } verdict_t;

  verdict_t    verdicts_due[$];
  int unsigned fails = 0;

  // Running scan of the current text
  logic [1:0]  cont_left;
  utf8_rule_e  cont_rule;
  logic        utf8_ok;
  logic        gbk_trail_due;
  logic        gbk_ok;
  logic        ascii_ok;

  assign fails_o        = fails;
  assign verdicts_due_o = verdicts_due.size();

  function automatic logic cont_fits(logic [7:0] b, utf8_rule_e rule);
    case (rule)
      RULE_A0BF: return b >= ContA0 && b <= ContMax;
      RULE_809F: return b >= ContMin && b <= Cont9F;
      RULE_90BF: return b >= Cont90 && b <= ContMax;
      RULE_808F: return b >= ContMin && b <= Cont8F;
      default:   return b >= ContMin && b <= ContMax;
    endcase
  endfunction

  task automatic restart_scan();
    cont_left     = 2'd0;
    cont_rule     = RULE_ANY;
    utf8_ok       = 1'b1;
    gbk_trail_due = 1'b0;
    gbk_ok        = 1'b1;
    ascii_ok      = 1'b1;
  endtask

  task automatic scan_byte(logic [7:0] b, logic last);
    verdict_t v;
    if (utf8_ok) begin
      if (cont_left != 2'd0) begin
        if (cont_fits(b, cont_rule)) begin
          cont_left = cont_left - 2'd1;
        end else begin
          utf8_ok   = 1'b0;
          cont_left = 2'd0;
        end
        cont_rule = RULE_ANY;
      end else if (b > ByteAsciiMax) begin
        if (b >= Utf8Lead2Min && b <= Utf8Lead2Max) begin
          cont_left = 2'd1;
          cont_rule = RULE_ANY;
        end else if (b == Utf8E0) begin
          cont_left = 2'd2;
          cont_rule = RULE_A0BF;
        end else if (b == Utf8ED) begin
          cont_left = 2'd2;
          cont_rule = RULE_809F;
        end else if (b > Utf8E0 && b <= Utf8Lead3Max) begin
          cont_left = 2'd2;
          cont_rule = RULE_ANY;
        end else if (b == Utf8F0) begin
          cont_left = 2'd3;
          cont_rule = RULE_90BF;
        end else if (b == Utf8F4) begin
          cont_left = 2'd3;
          cont_rule = RULE_808F;
        end else if (b > Utf8F0 && b < Utf8F4) begin
          cont_left = 2'd3;
          cont_rule = RULE_ANY;
        end else begin
          utf8_ok = 1'b0;
        end
      end
    end

    if (gbk_ok) begin
      if (gbk_trail_due) begin
        gbk_trail_due = 1'b0;
        if (!((b >= GbkTrailLo && b <= GbkTrailLoMx) || (b >= ContMin && b <= GbkLeadMax)))
          gbk_ok = 1'b0;
      end else if (b >= GbkLeadMin && b <= GbkLeadMax) begin
        gbk_trail_due = 1'b1;
      end else if (b > ByteAsciiMax) begin
        gbk_ok = 1'b0;
      end
    end

    if (b > ByteAsciiMax) ascii_ok = 1'b0;

    if (last) begin
      // A text cut off inside a sequence fails that check
      if (cont_left != 2'd0) utf8_ok = 1'b0;
      if (gbk_trail_due) gbk_ok = 1'b0;
      if (utf8_ok)       v.enc = ENC_UTF8;
      else if (gbk_ok)   v.enc = ENC_GBK;
      else if (ascii_ok) v.enc = ENC_ASCII;
      else               v.enc = ENC_UNKNOWN;
      v.utf8_ok  = utf8_ok;
      v.gbk_ok   = gbk_ok;
      v.ascii_ok = ascii_ok;
      verdicts_due = {verdicts_due, v};
      restart_scan();
    end
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial restart_scan();

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) scan_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (verdicts_due.size() == 0) begin
          fails++;
          $display("%0t: result word expected none, actual %h", $time, m_axis_tdata_i);
        end else begin
          want = verdicts_due.pop_front();
          compare_field("encoding", 32'(want.enc), 32'(m_axis_tdata_i[1:0]));
          compare_field("utf8_valid", 32'(want.utf8_ok), 32'(m_axis_tdata_i[2]));
          compare_field("gbk_valid", 32'(want.gbk_ok), 32'(m_axis_tdata_i[3]));
          compare_field("ascii_valid", 32'(want.ascii_ok), 32'(m_axis_tdata_i[4]));
          compare_field("padding", 0, 32'(m_axis_tdata_i[7:5]));
        end
      end
    end
  end

endmodule

### tb/text_encoding_detector_tb.sv
module text_encoding_detector_tb
  import ted_pkg::*;
;

  localparam int unsigned TotalBytes = 1450;
  localparam int unsigned HoldStart  = 600;
  localparam int unsigned HoldLen    = 400;
  localparam int unsigned TailCycles = 12;
  localparam int unsigned CycleLimit = 200000;

  typedef enum {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_e;
  typedef enum {TXT_UTF8, TXT_GBK, TXT_ASCII, TXT_NOISE} text_kind_e;

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid   = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata    = 8'h00;
  logic       s_axis_tlast    = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready   = 1'b0;
  logic [7:0] m_axis_tdata;

  int unsigned fails;
  int unsigned verdicts_due;
  int unsigned cycles     = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  logic [7:0]  text_q[$];

  text_encoding_detector i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  text_encoding_detector_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fails_o         (fails),
    .verdicts_due_o  (verdicts_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_byte(logic [7:0] b);
    text_q = {text_q, b};
  endtask

  task automatic push_range(int unsigned lo, int unsigned hi);
    logic [7:0] b;
    b = 8'($urandom_range(hi, lo));
    add_byte(b);
  endtask

  task automatic put_utf8_char();
    logic [7:0] lead;
    case ($urandom_range(0, 3))
      0: push_range(8'h00, 8'h7F);
      1: begin
        push_range(8'hC2, 8'hDF);
        push_range(8'h80, 8'hBF);
      end
      2: begin
        lead = 8'($urandom_range(8'hEF, 8'hE0));
        add_byte(lead);
        if (lead == 8'hE0)      push_range(8'hA0, 8'hBF);
        else if (lead == 8'hED) push_range(8'h80, 8'h9F);
        else                    push_range(8'h80, 8'hBF);
        push_range(8'h80, 8'hBF);
      end
      default: begin
        lead = 8'($urandom_range(8'hF4, 8'hF0));
        add_byte(lead);
        if (lead == 8'hF0)      push_range(8'h90, 8'hBF);
        else if (lead == 8'hF4) push_range(8'h80, 8'h8F);
        else                    push_range(8'h80, 8'hBF);
        push_range(8'h80, 8'hBF);
        push_range(8'h80, 8'hBF);
      end
    endcase
  endtask

  task automatic put_gbk_pair();
    if ($urandom_range(0, 3) == 0) begin
      push_range(8'h00, 8'h7F);
    end else begin
      push_range(8'h81, 8'hFE);
      if ($urandom_range(0, 1) == 0) push_range(8'h40, 8'h7E);
      else                           push_range(8'h80, 8'hFE);
    end
  endtask

  task automatic build_text();
    text_kind_e  kind;
    int unsigned n;
    int unsigned pos;
    logic [7:0]  b;
    text_q.delete();
    kind = text_kind_e'($urandom_range(0, 9) < 4 ? TXT_UTF8 :
                        $urandom_range(0, 5) < 3 ? TXT_GBK :
                        $urandom_range(0, 1) == 0 ? TXT_ASCII : TXT_NOISE);
    n = $urandom_range(1, 8);
    repeat (n) begin
      case (kind)
        TXT_UTF8:  put_utf8_char();
        TXT_GBK:   put_gbk_pair();
        TXT_ASCII: push_range(8'h00, 8'h7F);
        default:   push_range(8'h00, 8'hFF);
      endcase
    end
    // Break about a quarter of the texts: cut short, overwrite or insert a stray byte
    case ($urandom_range(0, 11))
      0: if (text_q.size() > 1) text_q = text_q[0:$-1];
      1: begin
        pos = $urandom_range(text_q.size() - 1, 0);
        b = 8'($urandom_range(8'hFF, 8'h00));
        text_q[pos] = b;
      end
      2: begin
        pos = $urandom_range(text_q.size(), 0);
        b = 8'($urandom_range(8'hFF, 8'h80));
        text_q.insert(pos, b);
      end
      default: ;
    endcase
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned rx_cycles;
    mode      = RX_OPEN;
    mode_left = 0;
    rx_cycles = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      // Hold off for a long stretch so the block fills and stalls its input
      if (rx_cycles >= HoldStart && rx_cycles < HoldStart + HoldLen)
        m_axis_tready <= 1'b0;
      else
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
          default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    text_q = '{8'h00};                      send_text();
    text_q = '{8'h7F};                      send_text();
    text_q = '{8'hC2, 8'h80};               send_text();
    text_q = '{8'hE0, 8'hA0, 8'h80};        send_text();
    text_q = '{8'hED, 8'h9F, 8'hBF};        send_text();
    text_q = '{8'hF0, 8'h90, 8'h80, 8'h80}; send_text();
    text_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_text();
    text_q = '{8'hFF};                      send_text();
    // overlong three-byte form
    text_q = '{8'hE0, 8'h80, 8'h80};        send_text();
    // text ends inside a sequence
    text_q = '{8'hC3};                      send_text();
    text_q = '{8'h81, 8'h40};               send_text();

    while (bytes_sent < TotalBytes) begin
      build_text();
      send_text();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fails == 0 && verdicts_due == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
